### src/lpbm_pkg.sv
// ----------------------------------------------------------------------------
// lpbm_pkg
// Shared types and constants of the LRU page buffer manager.
// ----------------------------------------------------------------------------
`default_nettype none

package lpbm_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int TABLES_DEF = 10;

  // configuration port
  localparam int              CFG_AW           = 3;
  localparam logic [4:0]      SIU_RESET        = 5'd16;
  localparam logic [CFG_AW-3:0] REG_SLOTS_IN_USE = '0;

  // request kinds
  localparam logic [1:0] KIND_READ        = 2'd0;
  localparam logic [1:0] KIND_WRITE       = 2'd1;
  localparam logic [1:0] KIND_FLUSH_TABLE = 2'd2;
  localparam logic [1:0] KIND_FLUSH_ALL   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  tbl_id;
    logic [31:0] pg_idx;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        writeback;
    logic [3:0]  wb_table;
    logic [31:0] wb_page;
    logic        last;
  } out_t;

  // source of the result register
  typedef enum logic [1:0] {
    OSEL_NONE,
    OSEL_ACC,
    OSEL_PEND
  } osel_t;

  typedef struct packed {
    logic  capture;     // take the input beat
    logic  scan_acc;    // evaluate current slot for an access
    logic  flush_step;  // evaluate current slot for a flush, drop it if it matches
    logic  upd;         // finish an access: touch or fill
    logic  out_load;    // load result register
    osel_t osel;
    logic  out_last;
  } lpbm_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic bad;          // access with table id out of range
    logic match;        // current slot holds the requested page
    logic fl_dirty;     // current slot is flushed and dirty
    logic pend_valid;   // a flush write-back is parked
  } lpbm_sts_t;

endpackage

`default_nettype wire

### src/lpbm_ctrl.sv
// ----------------------------------------------------------------------------
// lpbm_ctrl
// Sequencer: walks the slots one per cycle, pausing when a flush output is blocked, and hands out datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbm_ctrl #(
  parameter int SLOTS = lpbm_pkg::SLOTS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      out_stall,
  output logic                           out_valid,
  input  wire lpbm_pkg::lpbm_sts_t       st,
  output lpbm_pkg::lpbm_cmd_t            cmd,
  output logic [$clog2(SLOTS)-1:0]       ci,
  output logic [$clog2(SLOTS)-1:0]       rd_addr
);

  localparam int SW = $clog2(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_FIN
  } state_t;

  state_t          state_r, state_nxt;
  logic [SW-1:0]   ci_r, ci_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  logic            last_slot;
  logic            push;

  assign out_free  = !out_valid_r || !out_stall;
  assign last_slot = (ci_r == SW'(SLOTS - 1));
  assign push      = st.fl_dirty && st.pend_valid;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ci_nxt    = ci_r;
    rd_addr   = ci_r;
    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          ci_nxt      = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!st.is_flush) begin
          if (st.bad) begin
            state_nxt = S_FIN;
          end else begin
            cmd.scan_acc = 1'b1;
            if (st.match || last_slot) begin
              state_nxt = S_UPD;
            end else begin
              ci_nxt  = ci_r + SW'(1);
              rd_addr = ci_r + SW'(1);
            end
          end
        end else if (!push || out_free) begin
          // a second dirty slot pushes the parked one out with last low
          cmd.flush_step = 1'b1;
          cmd.out_load   = push;
          cmd.osel       = lpbm_pkg::OSEL_PEND;
          if (last_slot) begin
            state_nxt = S_FIN;
          end else begin
            ci_nxt  = ci_r + SW'(1);
            rd_addr = ci_r + SW'(1);
          end
        end
      end
      S_UPD: begin
        if (out_free) begin
          cmd.upd      = 1'b1;
          cmd.out_load = 1'b1;
          cmd.osel     = lpbm_pkg::OSEL_ACC;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.osel     = st.pend_valid ? lpbm_pkg::OSEL_PEND : lpbm_pkg::OSEL_NONE;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ci_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ci_r        <= ci_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign ci        = ci_r;

endmodule

`default_nettype wire

### src/lpbm_dp.sv
// ----------------------------------------------------------------------------
// lpbm_dp
// Datapath: tag memory, per-slot valid/dirty/recency cells, scan capture,
// parked flush write-back and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbm_dp #(
  parameter int SLOTS  = lpbm_pkg::SLOTS_DEF,
  parameter int TABLES = lpbm_pkg::TABLES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire lpbm_pkg::in_t             in_data,
  input  wire lpbm_pkg::lpbm_cmd_t       cmd,
  input  wire logic [$clog2(SLOTS)-1:0]  ci,
  input  wire logic [$clog2(SLOTS)-1:0]  rd_addr,
  output lpbm_pkg::lpbm_sts_t            st,
  output lpbm_pkg::out_t                 out_data,
  input  wire logic                      cfg_we,
  input  wire logic [4:0]                cfg_wdata,
  output logic [4:0]                     cfg_rdata
);

  localparam int SW   = $clog2(SLOTS);
  localparam int AGEW = SW;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int CW   = (CNTW > 5) ? CNTW : 5;

  // item and configuration
  lpbm_pkg::in_t   item_r;
  logic [4:0]      siu_r;

  // tag store: {table, page}
  logic [35:0]     tag_mem [SLOTS];
  logic [35:0]     rd_tag_r;

  // per-slot cells
  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] dirty_r;
  logic [AGEW-1:0]  age_r   [SLOTS];
  logic [AGEW-1:0]  age_nxt [SLOTS];
  logic [CNTW-1:0]  cnt_r;

  // scan capture
  logic             hit_found_r;
  logic [SW-1:0]    hit_slot_r;
  logic [AGEW-1:0]  hit_age_r;
  logic             free_found_r;
  logic [SW-1:0]    free_slot_r;
  logic [SW-1:0]    lru_slot_r;
  logic             lru_dirty_r;
  logic [3:0]       lru_tbl_r;
  logic [31:0]      lru_pg_r;

  // parked flush write-back
  logic             pend_valid_r;
  logic [SW-1:0]    pend_slot_r;
  logic [3:0]       pend_tbl_r;
  logic [31:0]      pend_pg_r;

  lpbm_pkg::out_t   out_r, out_nxt;

  logic [3:0]       cur_tbl;
  logic [31:0]      cur_pg;
  logic             cur_v;
  logic             cur_d;
  logic [AGEW-1:0]  cur_age;
  logic             is_acc;
  logic             is_write;
  logic             tid_ok;
  logic             cur_match;
  logic             fm;
  logic [CNTW-1:0]  cnt_m1;
  logic             lru_here;
  logic [4:0]       siu1;
  logic             full;
  logic [SW-1:0]    upd_slot;
  logic [CNTW-1:0]  th;
  logic             wb;
  logic             drop;

  assign cur_tbl  = rd_tag_r[35:32];
  assign cur_pg   = rd_tag_r[31:0];
  assign cur_v    = valid_r[ci];
  assign cur_d    = dirty_r[ci];
  assign cur_age  = age_r[ci];

  assign is_acc   = (item_r.kind == lpbm_pkg::KIND_READ) ||
                    (item_r.kind == lpbm_pkg::KIND_WRITE);
  assign is_write = (item_r.kind == lpbm_pkg::KIND_WRITE);
  assign tid_ok   = (item_r.tbl_id != 4'd0) && (item_r.tbl_id <= 4'(TABLES));

  assign cur_match = cur_v && (cur_tbl == item_r.tbl_id) && (cur_pg == item_r.pg_idx);
  assign fm        = cur_v && ((item_r.kind == lpbm_pkg::KIND_FLUSH_ALL) ||
                               (cur_tbl == item_r.tbl_id));

  // ranks are a permutation of 0..cnt-1, so the oldest slot has rank cnt-1
  assign cnt_m1   = cnt_r - CNTW'(1);
  assign lru_here = cur_v && (CNTW'(cur_age) == cnt_m1);

  assign siu1 = (siu_r == 5'd0) ? 5'd1 : siu_r;
  assign full = (CW'(cnt_r) >= CW'(siu1)) || (cnt_r == CNTW'(SLOTS));

  assign upd_slot = hit_found_r ? hit_slot_r : (full ? lru_slot_r : free_slot_r);
  // slots younger than th move back one rank
  assign th       = hit_found_r ? CNTW'(hit_age_r) : (full ? cnt_m1 : cnt_r);
  assign wb       = !hit_found_r && full && lru_dirty_r;
  assign drop     = cmd.flush_step && fm;

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      age_nxt[j] = age_r[j];
      if (cmd.upd) begin
        if (SW'(j) == upd_slot) begin
          age_nxt[j] = '0;
        end else if (valid_r[j] && (CNTW'(age_r[j]) < th)) begin
          age_nxt[j] = age_r[j] + AGEW'(1);
        end
      end else if (drop) begin
        if (valid_r[j] && (age_r[j] > cur_age)) begin
          age_nxt[j] = age_r[j] - AGEW'(1);
        end
      end
    end
  end

  always_comb begin
    out_nxt = '0;
    unique case (cmd.osel)
      lpbm_pkg::OSEL_ACC: begin
        out_nxt.hit       = hit_found_r;
        out_nxt.slot      = 4'(upd_slot);
        out_nxt.writeback = wb;
        out_nxt.wb_table  = wb ? lru_tbl_r : 4'd0;
        out_nxt.wb_page   = wb ? lru_pg_r : 32'd0;
        out_nxt.last      = cmd.out_last;
      end
      lpbm_pkg::OSEL_PEND: begin
        out_nxt.slot      = 4'(pend_slot_r);
        out_nxt.writeback = 1'b1;
        out_nxt.wb_table  = pend_tbl_r;
        out_nxt.wb_page   = pend_pg_r;
        out_nxt.last      = cmd.out_last;
      end
      lpbm_pkg::OSEL_NONE: begin
        out_nxt.last      = cmd.out_last;
      end
      default: out_nxt = '0;
    endcase
  end

  // tag memory
  always_ff @(posedge clk) begin
    if (cmd.upd && !hit_found_r) begin
      tag_mem[upd_slot] <= {item_r.tbl_id, item_r.pg_idx};
    end
    rd_tag_r <= tag_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      siu_r        <= lpbm_pkg::SIU_RESET;
      valid_r      <= '0;
      dirty_r      <= '0;
      cnt_r        <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        siu_r <= cfg_wdata;
      end
      if (cmd.capture) begin
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
        pend_valid_r <= 1'b0;
      end
      if (cmd.scan_acc) begin
        if (cur_match) begin
          hit_found_r <= 1'b1;
        end
        if (!cur_v && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end
      if (cmd.upd) begin
        valid_r[upd_slot] <= 1'b1;
        dirty_r[upd_slot] <= hit_found_r ? (dirty_r[upd_slot] || is_write) : is_write;
        if (!hit_found_r && !full) begin
          cnt_r <= cnt_r + CNTW'(1);
        end
      end
      if (drop) begin
        valid_r[ci] <= 1'b0;
        dirty_r[ci] <= 1'b0;
        cnt_r       <= cnt_r - CNTW'(1);
        if (cur_d) begin
          pend_valid_r <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    for (int j = 0; j < SLOTS; j++) begin
      age_r[j] <= age_nxt[j];
    end
    if (cmd.scan_acc) begin
      if (cur_match) begin
        hit_slot_r <= ci;
        hit_age_r  <= cur_age;
      end
      if (!cur_v && !free_found_r) begin
        free_slot_r <= ci;
      end
      if (lru_here) begin
        lru_slot_r  <= ci;
        lru_dirty_r <= cur_d;
        lru_tbl_r   <= cur_tbl;
        lru_pg_r    <= cur_pg;
      end
    end
    if (drop && cur_d) begin
      pend_slot_r <= ci;
      pend_tbl_r  <= cur_tbl;
      pend_pg_r   <= cur_pg;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign st.is_flush   = !is_acc;
  assign st.bad        = is_acc && !tid_ok;
  assign st.match      = cur_match;
  assign st.fl_dirty   = fm && cur_d;
  assign st.pend_valid = pend_valid_r;

  assign out_data  = out_r;
  assign cfg_rdata = siu_r;

endmodule

`default_nettype wire

### src/lru_page_buffer_manager_top.sv
// ----------------------------------------------------------------------------
// lru_page_buffer_manager_top
// Tag and LRU replacement engine of a page buffer pool with write-back.
// ----------------------------------------------------------------------------
// One request at a time. After the accept cycle the block reads the tag
// memory one slot per cycle: an access stops at the first matching slot,
// otherwise it walks all SLOTS slots, then does the update; an access with
// an out-of-range table id skips the walk and yields an empty beat with
// last set. A flush always walks all SLOTS slots, holding a slot while the
// result side stalls; it yields one beat per dirty slot it drops, in slot
// order, with last on the final beat, or a single empty beat with last set.
// The single-port tag memory read is what sets the per-slot pace. A new
// request is taken as soon as the previous result is in the output register.
// Valid and dirty bits clear at reset; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_buffer_manager_top #(
  parameter int SLOTS  = lpbm_pkg::SLOTS_DEF,
  parameter int TABLES = lpbm_pkg::TABLES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire lpbm_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output lpbm_pkg::out_t                     out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lpbm_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int SW = $clog2(SLOTS);

  lpbm_pkg::lpbm_cmd_t cmd;
  lpbm_pkg::lpbm_sts_t st;
  logic [SW-1:0]       ci;
  logic [SW-1:0]       rd_addr;
  logic                reg_sel;
  logic                cfg_we;
  logic [4:0]          cfg_rdata;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[lpbm_pkg::CFG_AW-1:2] == lpbm_pkg::REG_SLOTS_IN_USE);
  assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {27'd0, cfg_rdata} : 32'd0;

  lpbm_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd),
    .ci        (ci),
    .rd_addr   (rd_addr)
  );

  lpbm_dp #(
    .SLOTS  (SLOTS),
    .TABLES (TABLES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .ci        (ci),
    .rd_addr   (rd_addr),
    .st        (st),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[4:0]),
    .cfg_rdata (cfg_rdata)
  );

  // a result never lands on top of one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken before the first was worked");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.scan_acc, cmd.flush_step, cmd.upd, cmd.capture}))
    else $error("conflicting datapath commands");

  a_upd_emits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> (cmd.out_load && cmd.out_last))
    else $error("access update without its result");

endmodule

`default_nettype wire
